[sv/stil_pkg.sv]
// ----------------------------------------------------------------------------
// stil_pkg
// Shared types and constants for the strip triangle index lookup block.
// ----------------------------------------------------------------------------
package stil_pkg;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 12;
    localparam int VAL_W  = 16;
    localparam int TRI_W  = 12;
    localparam int LEN_W  = 13;
    localparam int VTX_W  = 16;
    localparam int SC_W   = 9;
    localparam int TC_W   = 13;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // A strip of length L carries L - MIN_STRIP_LEN triangles
    localparam int MIN_STRIP_LEN = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LEN_WR = 2'd0,
        FUNC_IDX_WR = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic {
        REG_STRIP_COUNT = 1'b0,
        REG_TRI_COUNT   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic accept;
        logic walk;
        logic addr;
        logic idx_rd;
        logic capture;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic tri_over;
        logic walk_end;
        logic hit;
        logic ptr_over;
        logic out_free;
    } t_dp_stat;

endpackage

[sv/strip_triangle_index_lookup_core.sv]
// ----------------------------------------------------------------------------
// strip_triangle_index_lookup_core
// Maps a global triangle number to its three vertex indices in a set of
// concatenated triangle strips.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word: func 0 writes a
//   strip length, func 1 writes a vertex index entry, func 2 queries a
//   triangle, func 3 does nothing. Every word gives exactly one result word on
//   the output channel (o_out_valid / i_out_ready); writes return all zeros.
//   Strip and triangle counts are set over the APB port (0x0, 0x4); the user
//   must do so while idle, as the block does not enforce it.
// Timing:
//   One word at a time. A write, a no-op or a query at or past the triangle
//   count passes through the done state to the output register. A query
//   walks the strip length memory one entry per cycle, then the index
//   memory's single read port fetches the three vertices. A query that walks
//   all n strips without a hit, or one in strip k whose vertices fall past
//   the index list, skips the fetch. A new word is taken once the previous
//   result sits in the output register.
// Reset: clears the sequencer, the output valid and both count registers;
//   memory contents are undefined until written, with no clearing pass.
// Stall: while the receiver holds off, the result waits in the output
//   register; a following word is accepted and processed, then held.
// ----------------------------------------------------------------------------
module strip_triangle_index_lookup_core #(
    parameter int MAX_STRIPS  = 256,
    parameter int MAX_INDICES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_entry_position,
    input  logic [15:0] i_entry_value,
    input  logic [11:0] i_triangle_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_first_vertex,
    output logic [15:0] o_second_vertex,
    output logic [15:0] o_third_vertex,
    output logic        o_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stil_pkg::*;

    logic [SC_W-1:0] r_strip_count;
    logic [TC_W-1:0] r_triangle_count;
    logic            cfg_wr;
    t_reg_idx        reg_sel;
    t_dp_cmd         cmd;
    t_dp_stat        stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_count    <= '0;
            r_triangle_count <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_STRIP_COUNT: r_strip_count    <= pwdata[SC_W-1:0];
                REG_TRI_COUNT:   r_triangle_count <= pwdata[TC_W-1:0];
                default:         r_strip_count    <= r_strip_count;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_STRIP_COUNT: prdata = APB_DW'(r_strip_count);
            REG_TRI_COUNT:   prdata = APB_DW'(r_triangle_count);
            default:         prdata = '0;
        endcase
    end

    stil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    stil_dp #(
        .MAX_STRIPS  (MAX_STRIPS),
        .MAX_INDICES (MAX_INDICES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_func            (i_func),
        .i_entry_position  (i_entry_position),
        .i_entry_value     (i_entry_value),
        .i_triangle_number (i_triangle_number),
        .i_strip_count     (r_strip_count),
        .i_triangle_count  (r_triangle_count),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_first_vertex    (o_first_vertex),
        .o_second_vertex   (o_second_vertex),
        .o_third_vertex    (o_third_vertex),
        .o_out_of_range    (o_out_of_range)
    );

endmodule

[sv/stil_ctrl.sv]
// ----------------------------------------------------------------------------
// stil_ctrl
// Sequencer: accepts one word, walks the strip table, fetches three indices.
// ----------------------------------------------------------------------------
module stil_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    input  stil_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output stil_pkg::t_dp_cmd o_cmd
);
    import stil_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        n_state        = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((t_func'(i_func) == FUNC_QUERY) && !i_stat.tri_over) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = ST_DONE;
                end else if (i_stat.hit) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = i_stat.ptr_over ? ST_DONE : ST_RD0;
            end
            ST_RD0: begin
                o_cmd.idx_rd = 1'b1;
                n_state      = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.idx_rd  = 1'b1;
                o_cmd.capture = 1'b1;
                n_state       = ST_RD2;
            end
            ST_RD2: begin
                o_cmd.idx_rd  = 1'b1;
                o_cmd.capture = 1'b1;
                n_state       = ST_RD3;
            end
            ST_RD3: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/stil_dp.sv]
// ----------------------------------------------------------------------------
// stil_dp
// Datapath: strip length and index memories, walk registers, output register.
// ----------------------------------------------------------------------------
module stil_dp #(
    parameter int MAX_STRIPS  = 256,
    parameter int MAX_INDICES = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stil_pkg::t_dp_cmd          i_cmd,
    output stil_pkg::t_dp_stat         o_stat,
    input  logic [1:0]                 i_func,
    input  logic [11:0]                i_entry_position,
    input  logic [15:0]                i_entry_value,
    input  logic [11:0]                i_triangle_number,
    input  logic [8:0]                 i_strip_count,
    input  logic [12:0]                i_triangle_count,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [15:0]                o_first_vertex,
    output logic [15:0]                o_second_vertex,
    output logic [15:0]                o_third_vertex,
    output logic                       o_out_of_range
);
    import stil_pkg::*;

    localparam int SAW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
    localparam int SW  = $clog2(MAX_STRIPS + 1);
    localparam int CW  = (SW > SC_W) ? SW : SC_W;
    localparam int IAW = $clog2(MAX_INDICES);
    localparam int BW  = SAW + LEN_W + 1;
    localparam int PW  = (BW + 1 > 18) ? BW + 1 : 18;

    logic [LEN_W-1:0] r_len_mem [MAX_STRIPS];
    logic [VTX_W-1:0] r_idx_mem [MAX_INDICES];

    logic [LEN_W-1:0] r_len_rd;
    logic [VTX_W-1:0] r_idx_rd;
    logic [SW-1:0]    r_s;
    logic [SW-1:0]    n_s;
    logic [BW-1:0]    r_base;
    logic [TRI_W-1:0] r_tri;
    logic [IAW-1:0]   r_ptr;
    logic [VTX_W-1:0] r_v0, r_v1, r_v2;
    logic             r_odd;
    logic             r_err;
    logic             r_out_valid;
    logic [VTX_W-1:0] r_first, r_second, r_third;
    logic             r_oor;

    logic [LEN_W-1:0] tri_cnt;
    logic             walk_end;
    logic             hit;
    logic             adv;
    logic [SAW-1:0]   s_rd_addr;
    logic [PW-1:0]    p_sum;
    logic             ptr_over;
    logic             tri_over;
    logic             wr_len;
    logic             wr_idx;
    t_func            func;

    assign func     = t_func'(i_func);
    assign tri_over = ({1'b0, i_triangle_number} >= i_triangle_count);

    assign walk_end = (CW'(r_s) >= CW'(i_strip_count)) || (r_s >= SW'(MAX_STRIPS));
    assign tri_cnt  = (r_len_rd < LEN_W'(MIN_STRIP_LEN)) ? '0
                                                         : r_len_rd - LEN_W'(MIN_STRIP_LEN);
    assign hit      = ({1'b0, r_tri} < tri_cnt);
    assign adv      = i_cmd.walk && !walk_end && !hit;

    always_comb begin
        if (i_cmd.accept) begin
            n_s = '0;
        end else if (adv) begin
            n_s = r_s + 1'b1;
        end else begin
            n_s = r_s;
        end
    end

    // read the entry for the next walk step from n_s, so it is registered when the step starts
    assign s_rd_addr = (n_s < SW'(MAX_STRIPS)) ? n_s[SAW-1:0] : '0;

    assign p_sum    = PW'(r_base) + PW'(r_tri);
    assign ptr_over = (p_sum >= PW'(MAX_INDICES - 2));

    assign wr_len = i_cmd.accept && (func == FUNC_LEN_WR)
                    && (PW'(i_entry_position) < PW'(MAX_STRIPS));
    assign wr_idx = i_cmd.accept && (func == FUNC_IDX_WR)
                    && (PW'(i_entry_position) < PW'(MAX_INDICES));

    always_ff @(posedge i_clk) begin
        if (wr_len) begin
            r_len_mem[i_entry_position[SAW-1:0]] <= i_entry_value[LEN_W-1:0];
        end
        r_len_rd <= r_len_mem[s_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_idx) begin
            r_idx_mem[IAW'(i_entry_position)] <= i_entry_value;
        end
        r_idx_rd <= r_idx_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (i_cmd.accept) begin
            r_tri  <= i_triangle_number;
            r_base <= '0;
            r_err  <= (func == FUNC_QUERY) && tri_over;
            r_v0   <= '0;
            r_v1   <= '0;
            r_v2   <= '0;
            r_odd  <= 1'b0;
        end else begin
            if (i_cmd.walk) begin
                if (walk_end) begin
                    r_err <= 1'b1;
                end else if (!hit) begin
                    r_tri  <= r_tri - tri_cnt[TRI_W-1:0];
                    r_base <= r_base + BW'(r_len_rd);
                end
            end
            if (i_cmd.addr) begin
                r_ptr <= p_sum[IAW-1:0];
                r_odd <= r_tri[0];
                if (ptr_over) begin
                    r_err <= 1'b1;
                end
            end
            if (i_cmd.idx_rd) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.capture) begin
                r_v0 <= r_v1;
                r_v1 <= r_v2;
                r_v2 <= r_idx_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // swap the first two indices on odd positions to keep the winding
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_first  <= r_odd ? r_v1 : r_v0;
            r_second <= r_odd ? r_v0 : r_v1;
            r_third  <= r_v2;
            r_oor    <= r_err;
        end
    end

    assign o_stat.tri_over = tri_over;
    assign o_stat.walk_end = walk_end;
    assign o_stat.hit      = hit;
    assign o_stat.ptr_over = ptr_over;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_first_vertex  = r_first;
    assign o_second_vertex = r_second;
    assign o_third_vertex  = r_third;
    assign o_out_of_range  = r_oor;

endmodule
